/* src/euler_to_camera_basis_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the camera basis core
// Each macro is empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_CAMERA_BASIS_CORE_DEFINES_SVH
`define EULER_TO_CAMERA_BASIS_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define E2CB_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define E2CB_ASSERT_RESET(lbl, clk, rst_n, sig, msg) \
    lbl: assert property (@(posedge clk) !rst_n |=> !(sig)) else $error(msg);
`else
`define E2CB_ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define E2CB_ASSERT_RESET(lbl, clk, rst_n, sig, msg)
`endif
`endif

/* src/e2cb_pkg.sv */
// ----------------------------------------------------------------------------
// e2cb_pkg
// Shared constants, types, a rounding helper and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package e2cb_pkg;

    localparam int ANG_W      = 18;
    localparam int Q14_W      = 16;
    localparam int CORDIC_N   = 20;
    localparam int CW         = 34;
    localparam int ZW         = 26;
    localparam int FULL_TURN  = 92160;
    localparam int HALF_TURN  = 46080;
    localparam int QUART_TURN = 23040;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [Q14_W-1:0] ONE_Q14 = 16'sd16384;

    typedef logic signed [Q14_W-1:0] q14_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } cordic_t;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                0:  r = 26'sd2949120;
                1:  r = 26'sd1740967;
                2:  r = 26'sd919879;
                3:  r = 26'sd466945;
                4:  r = 26'sd234379;
                5:  r = 26'sd117305;
                6:  r = 26'sd58666;
                7:  r = 26'sd29335;
                8:  r = 26'sd14668;
                9:  r = 26'sd7334;
                10: r = 26'sd3667;
                11: r = 26'sd1833;
                12: r = 26'sd917;
                13: r = 26'sd458;
                14: r = 26'sd229;
                15: r = 26'sd115;
                16: r = 26'sd57;
                17: r = 26'sd29;
                18: r = 26'sd14;
                19: r = 26'sd7;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // round a scaled value half up, shift, clamp to +-1.0
    function automatic q14_t round_clamp(input logic signed [CW+1:0] v, input int sh);
        logic signed [CW+1:0] t;
        begin
            t = (v + (36'sd1 <<< (sh - 1))) >>> sh;
            if (t > 36'sd16384)
                return ONE_Q14;
            else if (t < -36'sd16384)
                return -ONE_Q14;
            else
                return t[Q14_W-1:0];
        end
    endfunction

endpackage

/* src/e2cb_reduce.sv */
// ----------------------------------------------------------------------------
// e2cb_reduce
// Registered range reduction of one angle into [-90, 90] degrees plus flip.
// ----------------------------------------------------------------------------
module e2cb_reduce
(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [e2cb_pkg::ANG_W-1:0]   ang,
    output e2cb_pkg::cordic_t                   q
);

    logic signed [e2cb_pkg::ANG_W:0]  r;
    logic signed [e2cb_pkg::ANG_W:0]  rr;
    logic                             fl;
    e2cb_pkg::cordic_t                q_next;
    e2cb_pkg::cordic_t                q_reg;

    always_comb
    begin
        r = {ang[e2cb_pkg::ANG_W-1], ang};
        // input spans under two turns each way: two corrections suffice
        if (r >= 19'(e2cb_pkg::FULL_TURN))
            r = r - 19'(e2cb_pkg::FULL_TURN);
        if (r < -19'(e2cb_pkg::FULL_TURN))
            r = r + 19'(e2cb_pkg::FULL_TURN);
        if (r >= 19'(e2cb_pkg::HALF_TURN))
            r = r - 19'(e2cb_pkg::FULL_TURN);
        if (r < -19'(e2cb_pkg::HALF_TURN))
            r = r + 19'(e2cb_pkg::FULL_TURN);
        fl = 1'b0;
        rr = r;
        if (r > 19'(e2cb_pkg::QUART_TURN))
        begin
            rr = r - 19'(e2cb_pkg::HALF_TURN);
            fl = 1'b1;
        end
        else if (r < -19'(e2cb_pkg::QUART_TURN))
        begin
            rr = r + 19'(e2cb_pkg::HALF_TURN);
            fl = 1'b1;
        end
        q_next.x    = e2cb_pkg::CORDIC_GAIN;
        q_next.y    = '0;
        // rr lies within a quarter turn, so its low bits carry the sign
        q_next.z    = {rr[e2cb_pkg::ZW-9:0], 8'd0};
        q_next.flip = fl;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

/* src/e2cb_cordic.sv */
// ----------------------------------------------------------------------------
// e2cb_cordic
// Pipelined rotation CORDIC, two micro-rotations per register stage.
// ----------------------------------------------------------------------------
module e2cb_cordic
(
    input  logic                              clk,
    input  logic [e2cb_pkg::CORDIC_N/2-1:0]   en,
    input  e2cb_pkg::cordic_t                 d,
    output e2cb_pkg::q14_t                    sin_q,
    output e2cb_pkg::q14_t                    cos_q
);

    localparam int NS = e2cb_pkg::CORDIC_N / 2;

    e2cb_pkg::cordic_t st_reg [NS];
    e2cb_pkg::cordic_t st_next [NS];
    e2cb_pkg::q14_t    s_r;
    e2cb_pkg::q14_t    c_r;

    always_comb
    begin
        e2cb_pkg::cordic_t t;
        for (int k = 0; k < NS; k++)
        begin
            t = (k == 0) ? d : st_reg[k-1];
            for (int j = 0; j < 2; j++)
            begin
                logic signed [e2cb_pkg::CW-1:0] dx;
                logic signed [e2cb_pkg::CW-1:0] dy;
                dx = t.y >>> (2*k + j);
                dy = t.x >>> (2*k + j);
                if (!t.z[e2cb_pkg::ZW-1])
                begin
                    t.x = t.x - dx;
                    t.y = t.y + dy;
                    t.z = t.z - e2cb_pkg::atan_entry(2*k + j);
                end
                else
                begin
                    t.x = t.x + dx;
                    t.y = t.y - dy;
                    t.z = t.z + e2cb_pkg::atan_entry(2*k + j);
                end
            end
            st_next[k] = t;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
            if (en[k])
                st_reg[k] <= st_next[k];
    end

    always_comb
    begin
        s_r = e2cb_pkg::round_clamp({{2{st_reg[NS-1].y[e2cb_pkg::CW-1]}}, st_reg[NS-1].y}, 16);
        c_r = e2cb_pkg::round_clamp({{2{st_reg[NS-1].x[e2cb_pkg::CW-1]}}, st_reg[NS-1].x}, 16);
        sin_q = st_reg[NS-1].flip ? -s_r : s_r;
        cos_q = st_reg[NS-1].flip ? -c_r : c_r;
    end

endmodule

/* src/euler_to_camera_basis_core.sv */
// ----------------------------------------------------------------------------
// euler_to_camera_basis_core
// Camera direction, right and up vectors from yaw and pitch angles.
// ----------------------------------------------------------------------------
// Usage: s_axis carries one angle pair per transfer; m_axis returns the nine
// Q1.14 basis components plus a degenerate flag, one transfer per input.
// The pipeline is one reduction stage, ten CORDIC stages (two
// micro-rotations each), one rounding/sign stage and the product stage,
// which is also the output register. A new pair is accepted every cycle;
// the CORDIC chain sets the depth. A stall on m_axis freezes the whole
// pipeline (global enable), so nothing is lost or repeated; s_axis_tready
// drops while the output register holds a result that the receiver is not
// taking.
// Reset clears all valid bits; payload registers are not reset.
// Degenerate: when the rounded cos pitch is zero, right and up are zero.
// ----------------------------------------------------------------------------
`include "euler_to_camera_basis_core_defines.svh"

module euler_to_camera_basis_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // yaw[17:0], pitch[35:18], in 1/256 degree
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata,   // dir_x,y,z, right_x,y,z, up_x,y,z
    output logic         m_axis_tuser    // degenerate
);

    localparam int NS = e2cb_pkg::CORDIC_N / 2;
    localparam int NV = NS + 3;

    logic [NV-1:0] vld_reg;
    logic [NV-1:0] vld_next;
    logic          adv;
    logic [NS-1:0] cen;

    e2cb_pkg::cordic_t ry;
    e2cb_pkg::cordic_t rp;
    e2cb_pkg::q14_t sy_c, cy_c, sp_c, cp_c;
    e2cb_pkg::q14_t sy_reg, cy_reg, sp_reg, cp_reg;

    // the pipe advances whenever the output slot is empty or being drained
    assign adv           = !vld_reg[NV-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[NV-1];

    always_comb
    begin
        vld_next = vld_reg;
        if (adv)
            vld_next = {vld_reg[NV-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign cen = {NS{adv}};

    e2cb_reduce u_red_y (.clk(clk), .en(adv), .ang(s_axis_tdata[17:0]),  .q(ry));
    e2cb_reduce u_red_p (.clk(clk), .en(adv), .ang(s_axis_tdata[35:18]), .q(rp));

    e2cb_cordic u_cor_y (.clk(clk), .en(cen), .d(ry), .sin_q(sy_c), .cos_q(cy_c));
    e2cb_cordic u_cor_p (.clk(clk), .en(cen), .d(rp), .sin_q(sp_c), .cos_q(cp_c));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sy_reg <= sy_c;
            cy_reg <= cy_c;
            sp_reg <= sp_c;
            cp_reg <= cp_c;
        end
    end

    // products and sign selection
    function automatic e2cb_pkg::q14_t mulq(input e2cb_pkg::q14_t a, input e2cb_pkg::q14_t b);
        logic signed [31:0] p;
        begin
            p = 32'(a) * 32'(b);
            return e2cb_pkg::round_clamp(36'(p), 14);
        end
    endfunction

    logic            neg;
    logic            dg;
    e2cb_pkg::q14_t  v [9];
    logic [143:0]    tdata_reg;
    logic            tuser_reg;

    always_comb
    begin
        dg  = (cp_reg == '0);
        neg = cp_reg[e2cb_pkg::Q14_W-1];
        v[0] = mulq(cy_reg, cp_reg);
        v[1] = sp_reg;
        v[2] = mulq(sy_reg, cp_reg);
        v[3] = neg ? sy_reg : -sy_reg;
        v[4] = '0;
        v[5] = neg ? -cy_reg : cy_reg;
        v[6] = mulq(neg ? cy_reg : -cy_reg, sp_reg);
        v[7] = neg ? -cp_reg : cp_reg;
        v[8] = mulq(neg ? sy_reg : -sy_reg, sp_reg);
        if (dg)
            for (int k = 3; k < 9; k++)
                v[k] = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 9; k++)
                tdata_reg[16*k +: 16] <= v[k];
            tuser_reg <= dg;
        end
    end

    assign m_axis_tdata = tdata_reg;
    assign m_axis_tuser = tuser_reg;

    `E2CB_ASSERT_RESET(a_rst_empty, clk, rst_n, m_axis_tvalid, "output valid after reset")
    `E2CB_ASSERT_IMPL(a_hold, clk, rst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result dropped")
    `E2CB_ASSERT_IMPL(a_ry0, clk, rst_n, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[143:48] == '0), "degenerate basis")
    `E2CB_ASSERT_IMPL(a_ry, clk, rst_n, m_axis_tvalid |-> (m_axis_tdata[79:64] == '0), "right_y not zero")

endmodule
